FILE: rtl/dnbs_pkg.sv
// shared types, widths and codes for the directional nearest box selector
// no dependencies
package dnbs_pkg;

    localparam int COORD_WIDTH    = 20;
    localparam int MAX_CANDIDATES = 256;

    localparam int CW     = COORD_WIDTH;
    // count saturates at MAX_CANDIDATES + 1 to mark overflow
    localparam int CNT_W  = $clog2(MAX_CANDIDATES + 2);
    localparam int IDX_W  = (MAX_CANDIDATES > 2) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int IDX_OUT_W = 8;

    localparam int IN_FIELDS_W = 4 * CW + 3;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = 3;

    localparam logic [1:0] OP_FOCUS  = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_CAND   = 2'd2;

    localparam logic [2:0] DIR_NONE  = 3'd0;
    localparam logic [2:0] DIR_UP    = 3'd1;
    localparam logic [2:0] DIR_DOWN  = 3'd2;
    localparam logic [2:0] DIR_LEFT  = 3'd3;
    localparam logic [2:0] DIR_RIGHT = 3'd4;

    typedef struct packed {
        logic signed [CW-1:0] y_max;
        logic signed [CW-1:0] x_max;
        logic signed [CW-1:0] y_min;
        logic signed [CW-1:0] x_min;
    } box_t;

    typedef struct packed {
        logic [1:0] op;
        box_t       box;
        logic [2:0] dir;
        logic       is_focused;
        logic       last;
    } item_t;

    typedef struct packed {
        logic touch;
        logic better;
    } cmp_t;

    // found in the lowest bit
    typedef struct packed {
        logic                 overflow;
        logic [IDX_OUT_W-1:0] best_index;
        logic                 found;
    } res_t;

    localparam int OUT_TDATA_W = (($bits(res_t) + 7) / 8) * 8;

endpackage

FILE: rtl/directional_nearest_box_select.sv
// Path: a word is accepted into the input register; a word that ends a query then
// moves its result into the result register, which drives m_tvalid and m_tdata.
// Throughput: one word per cycle while not stalled; the running best updates from the input register.
// Input stalls only when the result register is full and not being taken.
// Reset (rst_n low, asynchronous) clears the focused and search boxes, direction,
// best index, found flag and candidate count; both stages come up empty.
module directional_nearest_box_select
    import dnbs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // x_min, y_min, x_max, y_max, dir, zero padding
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // op, is_focused
    input  logic [IN_TUSER_W-1:0]  s_tuser,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // found, best_index, overflow, zero padding
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    item_t            in_word;
    item_t            s1_reg;
    logic             s1_valid_reg;
    logic             s1_fire;

    box_t             focus_reg;
    box_t             search_reg;
    logic [2:0]       dir_reg;
    box_t             best_reg;
    logic [IDX_W-1:0] best_pos_reg, best_pos_next;
    logic             have_best_reg, have_best_next;
    logic [CNT_W-1:0] cand_count_reg, cand_count_next;

    res_t             out_res_reg, res_next;
    logic             out_valid_reg;

    cmp_t             cmp;
    logic             is_cand, emits, in_range, hit;
    logic [31:0]      pos_wide;

    always_comb
    begin
        in_word.op         = s_tuser[1:0];
        in_word.is_focused = s_tuser[2];
        in_word.last       = s_tlast;
        in_word.box.x_min  = s_tdata[CW-1:0];
        in_word.box.y_min  = s_tdata[2*CW-1:CW];
        in_word.box.x_max  = s_tdata[3*CW-1:2*CW];
        in_word.box.y_max  = s_tdata[4*CW-1:3*CW];
        in_word.dir        = s_tdata[4*CW+2:4*CW];
    end

    dnbs_compare u_compare (
        .cand   (s1_reg.box),
        .best   (best_reg),
        .focus  (focus_reg),
        .search (search_reg),
        .dir    (dir_reg),
        .result (cmp)
    );

    always_comb
    begin
        is_cand  = s1_reg.op == OP_CAND;
        emits    = is_cand && s1_reg.last;
        in_range = cand_count_reg < CNT_W'(MAX_CANDIDATES);
        hit      = in_range && !s1_reg.is_focused && cmp.touch && (!have_best_reg || cmp.better);

        cand_count_next = in_range ? cand_count_reg + 1'b1 : CNT_W'(MAX_CANDIDATES + 1);
        have_best_next  = have_best_reg || hit;
        best_pos_next   = hit ? cand_count_reg[IDX_W-1:0] : best_pos_reg;

        pos_wide            = 32'(best_pos_next);
        res_next.found      = have_best_next;
        res_next.best_index = have_best_next ? pos_wide[IDX_OUT_W-1:0] : '0;
        res_next.overflow   = cand_count_next > CNT_W'(MAX_CANDIDATES);
    end

    // a word leaves the input register unless it needs a result register that is full and not being taken
    assign s1_fire  = s1_valid_reg && (!emits || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_reg <= in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focus_reg      <= '0;
            search_reg     <= '0;
            dir_reg        <= DIR_NONE;
            best_pos_reg   <= '0;
            have_best_reg  <= 1'b0;
            cand_count_reg <= '0;
        end
        else if (s1_fire)
        begin
            unique case (s1_reg.op)
                OP_FOCUS:
                begin
                    focus_reg <= s1_reg.box;
                end
                OP_SEARCH:
                begin
                    search_reg <= s1_reg.box;
                    dir_reg    <= s1_reg.dir;
                end
                OP_CAND:
                begin
                    if (s1_reg.last)
                    begin
                        best_pos_reg   <= '0;
                        have_best_reg  <= 1'b0;
                        cand_count_reg <= '0;
                    end
                    else
                    begin
                        best_pos_reg   <= best_pos_next;
                        have_best_reg  <= have_best_next;
                        cand_count_reg <= cand_count_next;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // best box is only read while have_best is set
    always_ff @(posedge clk)
    begin
        if (s1_fire && is_cand && hit)
        begin
            best_reg <= s1_reg.box;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && emits)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && emits)
        begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_res_reg);

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cand_count_reg <= CNT_W'(MAX_CANDIDATES + 1))
        else $error("candidate count beyond saturation value");

    a_query_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_reg.op == OP_CAND && s1_reg.last
        |=> cand_count_reg == '0 && !have_best_reg)
        else $error("query state not cleared after result");

    a_best_counted: assert property (@(posedge clk) disable iff (!rst_n)
        have_best_reg |-> cand_count_reg != '0)
        else $error("best held without any counted candidate");

    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_res_reg.found |-> out_res_reg.best_index == '0)
        else $error("index given without a found candidate");
`endif

endmodule

FILE: rtl/dnbs_compare.sv
// candidate test: overlap with the search box and ranking against the best so far
// depends on dnbs_pkg
module dnbs_compare
    import dnbs_pkg::*;
(
    input  box_t       cand,
    input  box_t       best,
    input  box_t       focus,
    input  box_t       search,
    input  logic [2:0] dir,
    output cmp_t       result
);

    // doubled centre, one bit wider than a coordinate
    function automatic logic signed [CW:0] centre2(logic signed [CW-1:0] a,
                                                   logic signed [CW-1:0] b);
        return $signed({a[CW-1], a}) + $signed({b[CW-1], b});
    endfunction

    function automatic logic [CW:0] abs_diff(logic signed [CW:0] a, logic signed [CW:0] b);
        logic signed [CW+1:0] d;
        d = $signed({a[CW], a}) - $signed({b[CW], b});
        if (d < 0)
        begin
            d = -d;
        end
        return d[CW:0];
    endfunction

    logic [CW:0]     off_cx, off_bx, off_cy, off_by;
    logic [2*CW+1:0] sq_cx, sq_cy, sq_bx, sq_by;
    logic [2*CW+2:0] dist_c, dist_b;
    logic            key_lt, key_eq, off_lt;

    always_comb
    begin
        off_cx = abs_diff(centre2(cand.x_min, cand.x_max), centre2(focus.x_min, focus.x_max));
        off_bx = abs_diff(centre2(best.x_min, best.x_max), centre2(focus.x_min, focus.x_max));
        off_cy = abs_diff(centre2(cand.y_min, cand.y_max), centre2(focus.y_min, focus.y_max));
        off_by = abs_diff(centre2(best.y_min, best.y_max), centre2(focus.y_min, focus.y_max));
    end

    // four independent squares side by side, then two adds and one compare
    assign sq_cx  = off_cx * off_cx;
    assign sq_cy  = off_cy * off_cy;
    assign sq_bx  = off_bx * off_bx;
    assign sq_by  = off_by * off_by;
    assign dist_c = {1'b0, sq_cx} + {1'b0, sq_cy};
    assign dist_b = {1'b0, sq_bx} + {1'b0, sq_by};

    always_comb
    begin
        result.touch = !(cand.x_max < search.x_min || search.x_max < cand.x_min ||
                         cand.y_max < search.y_min || search.y_max < cand.y_min);

        key_lt = 1'b0;
        key_eq = 1'b0;
        off_lt = 1'b0;
        case (dir)
            DIR_UP:
            begin
                key_lt = cand.y_min < best.y_min;
                key_eq = cand.y_min == best.y_min;
                off_lt = off_cx < off_bx;
            end
            DIR_DOWN:
            begin
                key_lt = cand.y_max > best.y_max;
                key_eq = cand.y_max == best.y_max;
                off_lt = off_cx < off_bx;
            end
            DIR_LEFT:
            begin
                key_lt = cand.x_max > best.x_max;
                key_eq = cand.x_max == best.x_max;
                off_lt = off_cy < off_by;
            end
            DIR_RIGHT:
            begin
                key_lt = cand.x_min < best.x_min;
                key_eq = cand.x_min == best.x_min;
                off_lt = off_cy < off_by;
            end
            default:
            begin
                key_lt = 1'b0;
                key_eq = 1'b0;
                off_lt = 1'b0;
            end
        endcase

        // no direction, and unused codes, rank by squared centre distance
        if (dir inside {DIR_UP, DIR_DOWN, DIR_LEFT, DIR_RIGHT})
        begin
            result.better = key_lt || (key_eq && off_lt);
        end
        else
        begin
            result.better = dist_c < dist_b;
        end
    end

endmodule
